FILE: sv/tlnvf_pkg.sv
// ----------------------------------------------------------------------------
// tlnvf_pkg: shared types and constants for the text line filter
// Character codes, the queue entry format, and helpers for BCD line numbers.
// ----------------------------------------------------------------------------
package tlnvf_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int NUM_LEN    = NUM_DIGITS + 1;
	localparam int BODY_MAX   = 4;
	localparam int BODY_AW    = 2;
	localparam int BLEN_W     = 3;
	localparam int RUN_MAX    = NUM_LEN + 1 + BODY_MAX;
	localparam int POS_W      = $clog2(RUN_MAX + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = 2;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_FF     = 8'hFF;
	localparam logic [7:0] CTRL_END  = 8'd32;
	localparam logic [7:0] HIGH_LO   = 8'd128;
	localparam logic [7:0] HIGH_CTRL = 8'd160;
	localparam logic [7:0] CARET_OFS = 8'd64;
	localparam logic [7:0] META_OFS  = 8'd128;

	localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NONBLANK_ONLY = 3'd0,
		REG_NUMBER_ALL    = 3'd1,
		REG_SQUEEZE_EMPTY = 3'd2,
		REG_MARK_EOL      = 3'd3,
		REG_CARET_TAB     = 3'd4,
		REG_VISIBLE_CTRL  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic nonblank_only;
		logic number_all;
		logic squeeze_empty;
		logic mark_eol;
		logic caret_tab;
		logic visible_ctrl;
	} cfg_t;

	typedef struct packed {
		logic                        num;
		logic [BCD_W-1:0]            bcd;
		logic                        dollar;
		logic [BLEN_W-1:0]           body_len;
		logic [BODY_MAX-1:0][7:0]    body;
	} job_t;

	function automatic logic bcd_all_nines(input logic [BCD_W-1:0] bcd);
		logic r;
		r = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd9) r = 1'b0;
		end
		return r;
	endfunction

	function automatic logic bcd_digits_ok(input logic [BCD_W-1:0] bcd);
		logic r;
		r = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[4*i +: 4] > 4'd9) r = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] r;
		logic             carry;
		r = bcd;
		carry = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (carry) begin
				if (bcd[4*i +: 4] == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = bcd[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Character k of the number field, counted from the left; leading zeros show as spaces.
	function automatic logic [7:0] num_char(input logic [BCD_W-1:0] bcd, input int k);
		int         idx;
		logic       zero_above;
		logic [3:0] d;
		idx = NUM_DIGITS - 1 - k;
		zero_above = 1'b1;
		d = 4'd0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (i >= idx && bcd[4*i +: 4] != 4'd0) zero_above = 1'b0;
			if (i == idx) d = bcd[4*i +: 4];
		end
		if (zero_above && idx > 0) return CH_SPACE;
		return CH_ZERO + 8'(d);
	endfunction

endpackage

FILE: sv/tlnvf_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces for the text line filter
// Input byte channel, rendered output channel and register write channel.
// ----------------------------------------------------------------------------
interface txt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       new_stream;

	modport source (output valid, in_byte, new_stream, input ready);
	modport sink   (input valid, in_byte, new_stream, output ready);
endinterface

interface txt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, out_byte, last_of_run, input ready);
	modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

interface txt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tlnvf_pkg::CFG_IDX_W-1:0] index;
	logic                           data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/tlnvf_front.sv
// ----------------------------------------------------------------------------
// tlnvf_front: input stage of the text line filter
// Holds the registers and line state, classifies each byte and queues a job.
// ----------------------------------------------------------------------------
module tlnvf_front (
	input  logic             clk,
	input  logic             arst_n,
	txt_in_if.sink           in_ch,
	txt_cfg_if.sink          cfg,
	input  logic             q_full,
	output logic             q_push,
	output tlnvf_pkg::job_t  q_job
);
	import tlnvf_pkg::*;

	cfg_t             cfg_q;
	logic             after_nl_q;
	logic [BCD_W-1:0] bcd_q;
	logic [1:0]       blank_run_q;
	logic             skipping_q;

	logic             accept;
	logic             is_nl;
	logic             na;
	logic [BCD_W-1:0] bcd_cur;
	logic [1:0]       br_cur;
	logic             sk_cur;
	logic [1:0]       br_nx;
	logic             sk_nx;
	logic             num;
	logic [BCD_W-1:0] bcd_nx;
	logic [7:0]       c;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign c           = in_ch.in_byte;
	assign is_nl       = (c == CH_NL);

	always_comb begin
		na      = in_ch.new_stream ? 1'b1 : after_nl_q;
		bcd_cur = in_ch.new_stream ? BCD_ONE : bcd_q;
		br_cur  = in_ch.new_stream ? 2'd0 : blank_run_q;
		sk_cur  = in_ch.new_stream ? 1'b0 : skipping_q;
		br_nx   = br_cur;
		sk_nx   = sk_cur;
		if (cfg_q.squeeze_empty && is_nl && na) begin
			if (br_cur != 2'd3) br_nx = br_cur + 2'd1;
			if (br_nx > 2'd1) sk_nx = 1'b1;
		end else if (!is_nl) begin
			br_nx = 2'd0;
			sk_nx = 1'b0;
		end
		if (cfg_q.nonblank_only) begin
			num = !is_nl && na;
		end else begin
			num = cfg_q.number_all && na;
		end
		num = num && !sk_nx;
		bcd_nx = (num && !bcd_all_nines(bcd_cur)) ? bcd_inc(bcd_cur) : bcd_cur;
	end

	always_comb begin
		q_job.num      = num;
		q_job.bcd      = bcd_cur;
		q_job.dollar   = cfg_q.mark_eol && is_nl;
		q_job.body_len = BLEN_W'(1);
		q_job.body     = '0;
		q_job.body[0]  = c;
		if (cfg_q.caret_tab && c == CH_TAB) begin
			q_job.body_len = BLEN_W'(2);
			q_job.body[0]  = CH_CARET;
			q_job.body[1]  = CH_I;
		end else if (cfg_q.visible_ctrl && !is_nl && c != CH_TAB) begin
			if (c < CTRL_END) begin
				q_job.body_len = BLEN_W'(2);
				q_job.body[0]  = CH_CARET;
				q_job.body[1]  = c + CARET_OFS;
			end else if (c == CH_DEL) begin
				q_job.body_len = BLEN_W'(2);
				q_job.body[0]  = CH_CARET;
				q_job.body[1]  = CH_QMARK;
			end else if (c >= HIGH_LO && c < HIGH_CTRL) begin
				q_job.body_len = BLEN_W'(4);
				q_job.body[0]  = CH_M;
				q_job.body[1]  = CH_DASH;
				q_job.body[2]  = CH_CARET;
				q_job.body[3]  = c - CARET_OFS;
			end else if (c >= HIGH_CTRL && c != CH_FF) begin
				q_job.body_len = BLEN_W'(3);
				q_job.body[0]  = CH_M;
				q_job.body[1]  = CH_DASH;
				q_job.body[2]  = c - META_OFS;
			end else if (c == CH_FF) begin
				q_job.body_len = BLEN_W'(4);
				q_job.body[0]  = CH_M;
				q_job.body[1]  = CH_DASH;
				q_job.body[2]  = CH_CARET;
				q_job.body[3]  = CH_QMARK;
			end
		end
	end

	assign q_push = accept && !sk_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_NONBLANK_ONLY: cfg_q.nonblank_only <= cfg.data;
				REG_NUMBER_ALL:    cfg_q.number_all    <= cfg.data;
				REG_SQUEEZE_EMPTY: cfg_q.squeeze_empty <= cfg.data;
				REG_MARK_EOL:      cfg_q.mark_eol      <= cfg.data;
				REG_CARET_TAB:     cfg_q.caret_tab     <= cfg.data;
				REG_VISIBLE_CTRL:  cfg_q.visible_ctrl  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_nl_q  <= 1'b1;
			bcd_q       <= BCD_ONE;
			blank_run_q <= 2'd0;
			skipping_q  <= 1'b0;
		end else if (accept) begin
			after_nl_q  <= is_nl;
			bcd_q       <= bcd_nx;
			blank_run_q <= br_nx;
			skipping_q  <= sk_nx;
		end
	end

	a_skip_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		skipping_q |-> blank_run_q >= 2'd2)
		else $error("skipping set with fewer than two blank lines");

	a_bcd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_digits_ok(bcd_q))
		else $error("line number holds a digit above nine");

	a_after_nl: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> after_nl_q == ($past(in_ch.in_byte) == CH_NL))
		else $error("after_newline does not follow the accepted byte");

endmodule

FILE: sv/tlnvf_queue.sv
// ----------------------------------------------------------------------------
// tlnvf_queue: job queue between the front and back stages
// Four entries; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module tlnvf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tlnvf_pkg::job_t  job_in,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output tlnvf_pkg::job_t  job_out
);
	import tlnvf_pkg::*;

	job_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full      = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign job_out   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/tlnvf_back.sv
// ----------------------------------------------------------------------------
// tlnvf_back: output stage of the text line filter
// Walks each queued job and sends one rendered byte per beat.
// ----------------------------------------------------------------------------
module tlnvf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tlnvf_pkg::job_t  q_job,
	output logic             q_pop,
	txt_out_if.source        out_ch
);
	import tlnvf_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic [POS_W-1:0]   nb;
	logic [POS_W-1:0]   total;
	logic [POS_W-1:0]   rel;
	logic [POS_W-1:0]   bidx;
	logic [7:0]         cur_byte;
	logic               cur_last;
	logic               advance;
	logic               load;

	always_comb begin
		nb       = q_job.num ? POS_W'(NUM_LEN) : '0;
		total    = nb + POS_W'(q_job.dollar) + POS_W'(q_job.body_len);
		rel      = pos_q - nb;
		bidx     = rel - POS_W'(q_job.dollar);
		cur_last = (pos_q == total - 1'b1);
		if (q_job.num && pos_q < POS_W'(NUM_LEN)) begin
			if (pos_q == POS_W'(NUM_DIGITS)) begin
				cur_byte = CH_TAB;
			end else begin
				cur_byte = num_char(q_job.bcd, int'(pos_q));
			end
		end else if (q_job.dollar && rel == '0) begin
			cur_byte = CH_DOLLAR;
		end else begin
			cur_byte = q_job.body[bidx[BODY_AW-1:0]];
		end
	end

	assign advance = !out_valid_q || out_ch.ready;
	assign load    = advance && q_valid;
	assign q_pop   = load && cur_last;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_byte    = out_byte_q;
	assign out_ch.last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (advance) out_valid_q <= q_valid;
			if (load) pos_q <= cur_last ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	a_pos_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> pos_q < total)
		else $error("byte position beyond the end of the run");

	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("job released from an empty queue");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> pos_q == '0)
		else $error("byte position not cleared after the last beat of a run");

endmodule

FILE: sv/text_line_number_visible_filter_unit.sv
// ----------------------------------------------------------------------------
// text_line_number_visible_filter_unit: text rendering filter
// Squeezes blank lines, numbers lines, and renders bytes in visible notation.
// ----------------------------------------------------------------------------
// Each input byte yields zero to eleven output beats: an optional six-digit
// line number and tab, an optional '$' before a newline, then the byte itself
// or its caret / M- form. The output stage sends one beat per cycle while the
// output channel is ready, so an expanded byte holds its run until all its beats
// are sent; a squeezed empty line is taken with no output. A four-entry job queue
// lets input keep flowing while a long run drains. The user must write registers
// through the configuration channel while the block is idle; it is not enforced.
module text_line_number_visible_filter_unit (
	input logic       clk,
	input logic       arst_n,
	txt_in_if.sink    in_ch,
	txt_out_if.source out_ch,
	txt_cfg_if.sink   cfg
);
	import tlnvf_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	job_t job_in;
	job_t job_out;

	tlnvf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (job_in)
	);

	tlnvf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.job_in    (job_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.job_out   (job_out)
	);

	tlnvf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_job   (job_out),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

FILE: tb/text_line_number_visible_filter_unit_test.sv
// ----------------------------------------------------------------------------
// text_line_number_visible_filter_unit_test: self-checking bench for the filter
// Drives text bytes under changing display settings and checks every rendered
// beat against the table's text or a local model of numbering, squeezing and
// visible notation. The run starts with a short table of hand-picked bytes
// and then moves on to random line-shaped traffic. Both sides idle at random,
// and the output is held off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module text_line_number_visible_filter_unit_test;
	import tlnvf_pkg::*;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 46;
	localparam int PRESSURE_PHASE = 3;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 24;
	localparam int MAX_REPORTS    = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Bit order of cfg_t: nonblank, all, squeeze, ends, tabs, nonprinting.
	localparam cfg_t MODE_RAW     = cfg_t'(6'b000000);
	localparam cfg_t MODE_VISIBLE = cfg_t'(6'b000111);
	localparam cfg_t MODE_NP_ONLY = cfg_t'(6'b000001);
	localparam cfg_t MODE_NUM_SQZ = cfg_t'(6'b011000);
	localparam cfg_t MODE_BOTH    = cfg_t'(6'b110000);
	localparam cfg_t MODE_FULL    = cfg_t'(6'b111111);

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} beat_t;

	typedef struct {
		bit    typed;
		string text;
	} typed_run_t;

	typedef struct {
		cfg_t       mode;
		logic [7:0] ch;
		bit         restart;
		bit         typed;
		string      text;
	} stim_row_t;

	logic clk;
	logic arst_n;

	txt_in_if  in_ch ();
	txt_out_if out_ch ();
	txt_cfg_if cfg ();

	text_line_number_visible_filter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	cfg_t             reg_mode   = MODE_RAW;
	bit               after_nl   = 1'b1;
	logic [BCD_W-1:0] line_bcd   = BCD_ONE;
	logic [1:0]       blank_run  = 2'd0;
	bit               skipping   = 1'b0;
	logic [7:0]       run_bytes[$];

	beat_t      beats_due[$];
	typed_run_t typed_runs[$];
	stim_row_t  plan[$];
	cfg_t       applied = MODE_RAW;

	int  bytes_offered = 0;
	int  bytes_taken   = 0;
	int  beats_seen    = 0;
	int  bad_beats     = 0;
	int  modes_used    = 0;
	bit  src_lazy      = 1'b0;
	bit  sink_lazy     = 1'b0;
	bit  hold_sink     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	function void render_byte(input logic [7:0] c, input bit restart);
		bit         nl;
		bit         lead;
		bit         nines;
		logic [3:0] d;
		run_bytes.delete();
		nl = (c == CH_NL);
		if (restart) begin
			after_nl  = 1'b1;
			line_bcd  = BCD_ONE;
			blank_run = 2'd0;
			skipping  = 1'b0;
		end
		if (reg_mode.squeeze_empty && nl && after_nl) begin
			if (blank_run < 2'd3) blank_run++;
			if (blank_run > 2'd1) skipping = 1'b1;
		end else if (!nl) begin
			blank_run = 2'd0;
			skipping  = 1'b0;
		end
		if (!skipping) begin
			if (after_nl && (reg_mode.nonblank_only ? !nl : reg_mode.number_all)) begin
				lead  = 1'b1;
				nines = 1'b1;
				for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
					d = line_bcd[4*i +: 4];
					if (d != 4'd9) nines = 1'b0;
					if (lead && d == 4'd0 && i > 0) begin
						run_bytes.push_back(CH_SPACE);
					end else begin
						lead = 1'b0;
						run_bytes.push_back(CH_ZERO + 8'(d));
					end
				end
				run_bytes.push_back(CH_TAB);
				if (!nines) begin
					for (int i = 0; i < NUM_DIGITS; i++) begin
						if (line_bcd[4*i +: 4] == 4'd9) begin
							line_bcd[4*i +: 4] = 4'd0;
						end else begin
							line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
							break;
						end
					end
				end
			end
			if (reg_mode.mark_eol && nl) run_bytes.push_back(CH_DOLLAR);
			if (reg_mode.caret_tab && c == CH_TAB) begin
				run_bytes.push_back(CH_CARET);
				run_bytes.push_back(CH_I);
			end else if (reg_mode.visible_ctrl && !nl && c != CH_TAB) begin
				if (c < CTRL_END) begin
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(c + CARET_OFS);
				end else if (c == CH_DEL) begin
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(CH_QMARK);
				end else if (c >= HIGH_LO && c < HIGH_CTRL) begin
					run_bytes.push_back(CH_M);
					run_bytes.push_back(CH_DASH);
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(c - CARET_OFS);
				end else if (c >= HIGH_CTRL && c < CH_FF) begin
					run_bytes.push_back(CH_M);
					run_bytes.push_back(CH_DASH);
					run_bytes.push_back(c - META_OFS);
				end else if (c == CH_FF) begin
					run_bytes.push_back(CH_M);
					run_bytes.push_back(CH_DASH);
					run_bytes.push_back(CH_CARET);
					run_bytes.push_back(CH_QMARK);
				end else begin
					run_bytes.push_back(c);
				end
			end else begin
				run_bytes.push_back(c);
			end
		end
		after_nl = nl;
	endfunction

	always @(posedge clk) begin
		typed_run_t tr;
		beat_t      got;
		beat_t      want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_NONBLANK_ONLY: reg_mode.nonblank_only = cfg.data;
					REG_NUMBER_ALL:    reg_mode.number_all    = cfg.data;
					REG_SQUEEZE_EMPTY: reg_mode.squeeze_empty = cfg.data;
					REG_MARK_EOL:      reg_mode.mark_eol      = cfg.data;
					REG_CARET_TAB:     reg_mode.caret_tab     = cfg.data;
					REG_VISIBLE_CTRL:  reg_mode.visible_ctrl  = cfg.data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				render_byte(in_ch.in_byte, in_ch.new_stream);
				tr = typed_runs.pop_front();
				if (tr.typed) begin
					for (int i = 0; i < tr.text.len(); i++) begin
						beats_due.push_back('{tr.text[i], i == tr.text.len() - 1});
					end
				end else begin
					foreach (run_bytes[i]) begin
						beats_due.push_back('{run_bytes[i], i == run_bytes.size() - 1});
					end
				end
				bytes_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.out_byte, out_ch.last_of_run};
				beats_seen++;
				if (beats_due.size() == 0) begin
					bad_beats++;
					if (bad_beats <= MAX_REPORTS)
						$display("Unexpected beat: byte %02h last %0b", got.ch, got.last);
				end else begin
					want = beats_due.pop_front();
					if (got.ch !== want.ch || got.last !== want.last) begin
						bad_beats++;
						if (bad_beats <= MAX_REPORTS)
							$display("Beat %0d mismatch: expected byte %02h last %0b, got byte %02h last %0b",
								beats_seen, want.ch, want.last, got.ch, got.last);
					end
				end
			end
		end
	end

	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = sink_lazy ? $urandom_range(0, 6) : 0;
			if (hold_sink) begin
				gap += HOLD_CYCLES;
				hold_sink = 1'b0;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic offer_byte(input logic [7:0] c, input bit restart, input bit typed,
			input string text);
		int gap;
		gap = src_lazy ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_runs.push_back('{typed, text});
		bytes_offered++;
		in_ch.valid      <= 1'b1;
		in_ch.in_byte    <= c;
		in_ch.new_stream <= restart;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic settle_idle();
		in_ch.valid <= 1'b0;
		while (bytes_taken != bytes_offered || beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input cfg_t m);
		cfg_reg_t regs[6];
		bit       vals[6];
		regs = '{REG_NONBLANK_ONLY, REG_NUMBER_ALL, REG_SQUEEZE_EMPTY,
			REG_MARK_EOL, REG_CARET_TAB, REG_VISIBLE_CTRL};
		vals = '{m.nonblank_only, m.number_all, m.squeeze_empty,
			m.mark_eol, m.caret_tab, m.visible_ctrl};
		for (int i = 0; i < 6; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= regs[i];
			cfg.data  <= vals[i];
			do @(posedge clk); while (!cfg.ready);
		end
		if ($urandom_range(0, 1)) begin
			cfg.index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
			cfg.data  <= 1'($urandom_range(0, 1));
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		applied = m;
		modes_used++;
	endtask

	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 8'($urandom_range(32, 126));
		if (r < 60) return CH_TAB;
		if (r < 72) return 8'($urandom_range(0, 31));
		if (r < 76) return CH_DEL;
		return 8'($urandom_range(128, 255));
	endfunction

	initial begin
		cfg_t m;
		int   count;
		int   len;
		arst_n           = 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.in_byte    <= 8'h00;
		in_ch.new_stream <= 1'b0;
		cfg.valid        <= 1'b0;
		cfg.index        <= REG_NONBLANK_ONLY;
		cfg.data         <= 1'b0;

		plan.push_back('{MODE_RAW,     8'h00,  1'b0, 1'b0, ""});
		plan.push_back('{MODE_RAW,     8'h41,  1'b0, 1'b1, "A"});
		plan.push_back('{MODE_RAW,     CH_TAB, 1'b0, 1'b1, "\t"});
		plan.push_back('{MODE_RAW,     CH_FF,  1'b1, 1'b0, ""});
		plan.push_back('{MODE_VISIBLE, 8'h00,  1'b0, 1'b1, "^@"});
		plan.push_back('{MODE_VISIBLE, 8'h1F,  1'b0, 1'b1, "^_"});
		plan.push_back('{MODE_VISIBLE, CH_DEL, 1'b0, 1'b1, "^?"});
		plan.push_back('{MODE_VISIBLE, 8'h80,  1'b0, 1'b1, "M-^@"});
		plan.push_back('{MODE_VISIBLE, 8'h9F,  1'b0, 1'b1, "M-^_"});
		plan.push_back('{MODE_VISIBLE, 8'hA0,  1'b0, 1'b1, "M- "});
		plan.push_back('{MODE_VISIBLE, 8'hFE,  1'b0, 1'b1, "M-~"});
		plan.push_back('{MODE_VISIBLE, CH_FF,  1'b0, 1'b1, "M-^?"});
		plan.push_back('{MODE_VISIBLE, CH_TAB, 1'b0, 1'b1, "^I"});
		plan.push_back('{MODE_VISIBLE, CH_NL,  1'b0, 1'b1, "$\n"});
		plan.push_back('{MODE_NP_ONLY, CH_TAB, 1'b0, 1'b1, "\t"});
		plan.push_back('{MODE_NUM_SQZ, 8'h78,  1'b1, 1'b1, "     1\tx"});
		plan.push_back('{MODE_NUM_SQZ, CH_NL,  1'b0, 1'b1, "\n"});
		plan.push_back('{MODE_NUM_SQZ, CH_NL,  1'b0, 1'b1, "     2\t\n"});
		plan.push_back('{MODE_NUM_SQZ, CH_NL,  1'b0, 1'b1, ""});
		plan.push_back('{MODE_NUM_SQZ, CH_NL,  1'b0, 1'b1, ""});
		plan.push_back('{MODE_NUM_SQZ, 8'h79,  1'b0, 1'b1, "     3\ty"});
		plan.push_back('{MODE_NUM_SQZ, 8'h7A,  1'b1, 1'b1, "     1\tz"});
		plan.push_back('{MODE_BOTH,    CH_NL,  1'b1, 1'b1, "\n"});
		plan.push_back('{MODE_BOTH,    8'h71,  1'b0, 1'b1, "     1\tq"});
		plan.push_back('{MODE_BOTH,    CH_NL,  1'b0, 1'b1, "\n"});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].mode != applied) begin
				settle_idle();
				write_mode(plan[i].mode);
			end
			offer_byte(plan[i].ch, plan[i].restart, plan[i].typed, plan[i].text);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) m = MODE_FULL;
			else if (p == 1) m = MODE_RAW;
			else m = cfg_t'(6'($urandom_range(0, 63)));
			settle_idle();
			write_mode(m);
			src_lazy  = ($urandom_range(0, 2) != 0);
			sink_lazy = ($urandom_range(0, 2) != 0);
			if (p == PRESSURE_PHASE) begin
				src_lazy  = 1'b0;
				hold_sink = 1'b1;
			end
			count = 0;
			while (count < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 85) begin
					len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					for (int k = 0; k < len; k++)
						offer_byte(text_byte(), $urandom_range(0, 39) == 0, 1'b0, "");
					offer_byte(CH_NL, $urandom_range(0, 39) == 0, 1'b0, "");
					count += len + 1;
				end else begin
					offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0, 1'b0, "");
					count++;
				end
			end
		end

		settle_idle();
		bad_beats += beats_due.size();
		$display("Run covered %0d text bytes and %0d rendered beats over %0d register settings,",
			bytes_taken, beats_seen, modes_used);
		$display("including one long output hold-off while input kept coming.");
		if (bad_beats == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
